@@ hw/rtl/avpm_pkg.sv @@
// Shared types and constants for the audio volume/pan mixer.
// Used by every module under hw/rtl; depends on nothing.
package avpm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PAN_W    = 8;
    localparam int VOL_W    = 8;
    localparam int ACC_W    = 32;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = SAMPLE_W + PAN_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = SAMPLE_W;

    localparam int FULL_VOLUME_DEF = 100;
    localparam int PAN_FULL        = 100;

    localparam logic [VOL_W-1:0] VOL_RESET = 8'd100;

    localparam logic [CFG_IDX_W-1:0] REG_MASTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MUSIC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT = 2'd2;

    typedef struct packed {
        logic [VOL_W-1:0] master;
        logic [VOL_W-1:0] music;
        logic [VOL_W-1:0] effect;
    } t_vol_cfg;

endpackage

@@ hw/rtl/avpm_cfg.sv @@
// Volume configuration registers of the mixer.
// Depends on avpm_pkg.
module avpm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [avpm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [avpm_pkg::VOL_W-1:0]       i_cfg_data,
    output avpm_pkg::t_vol_cfg               o_cfg
);

    avpm_pkg::t_vol_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.master <= avpm_pkg::VOL_RESET;
            r_cfg.music  <= avpm_pkg::VOL_RESET;
            r_cfg.effect <= avpm_pkg::VOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                avpm_pkg::REG_MASTER: r_cfg.master <= i_cfg_data;
                avpm_pkg::REG_MUSIC:  r_cfg.music  <= i_cfg_data;
                avpm_pkg::REG_EFFECT: r_cfg.effect <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/avpm_mul.sv @@
// Shared unsigned multiplier with registered product.
// Depends on avpm_pkg.
module avpm_mul (
    input  logic                          i_clk,
    input  logic [avpm_pkg::MUL_W-1:0]    i_a,
    input  logic [avpm_pkg::MUL_W-1:0]    i_b,
    output logic [avpm_pkg::PROD_W-1:0]   o_p
);

    logic [avpm_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= avpm_pkg::PROD_W'(i_a) * avpm_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ hw/rtl/avpm_core.sv @@
// Mixer sequencer: volume, scale and pan steps on the shared multiplier,
// saturating accumulator and output register. Depends on avpm_pkg, avpm_mul.
module avpm_core #(
    parameter int FULL_VOLUME = avpm_pkg::FULL_VOLUME_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  avpm_pkg::t_vol_cfg                 i_cfg,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [avpm_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic [avpm_pkg::IN_USER_W-1:0]     i_s_tuser,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [avpm_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int SW  = avpm_pkg::SAMPLE_W;
    localparam int PNW = avpm_pkg::PAN_W;
    localparam int VW  = avpm_pkg::VOL_W;
    localparam int AW  = avpm_pkg::ACC_W;
    localparam int MW  = avpm_pkg::MUL_W;
    localparam int PW  = avpm_pkg::PROD_W;
    localparam int PF  = avpm_pkg::PAN_FULL;
    localparam int PMW = $clog2(PF + 1);

    // floor(x/F) = (x*R) >> S, exact for x < 2^N with S = N + clog2(F)
    localparam int VOL_XW = 2 * VW;
    localparam int VOL_S  = VOL_XW + $clog2(FULL_VOLUME);
    localparam logic [PW-1:0] VOL_R =
        ((PW'(1) << VOL_S) + PW'(FULL_VOLUME) - PW'(1)) / PW'(FULL_VOLUME);
    localparam int SCL_XW = SW + VW;
    localparam int SCL_S  = SCL_XW + $clog2(FULL_VOLUME);
    localparam logic [PW-1:0] SCL_R =
        ((PW'(1) << SCL_S) + PW'(FULL_VOLUME) - PW'(1)) / PW'(FULL_VOLUME);
    localparam int PAN_XW = SW + PMW;
    localparam int PAN_S  = PAN_XW + $clog2(PF);
    localparam logic [PW-1:0] PAN_R =
        ((PW'(1) << PAN_S) + PW'(PF) - PW'(1)) / PW'(PF);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_VMUL = 3'd1;
    localparam logic [2:0] ST_VDIV = 3'd2;
    localparam logic [2:0] ST_SMUL = 3'd3;
    localparam logic [2:0] ST_SDIV = 3'd4;
    localparam logic [2:0] ST_PMUL = 3'd5;
    localparam logic [2:0] ST_PDIV = 3'd6;
    localparam logic [2:0] ST_ACC  = 3'd7;

    localparam logic signed [AW-1:0] OUT_MAX = AW'((1 << (SW - 1)) - 1);
    localparam logic signed [AW-1:0] OUT_MIN = -AW'(1 << (SW - 1));

    logic [2:0]             r_state, n_state;
    logic [SW:0]            r_mag;
    logic                   r_neg;
    logic                   r_kind;
    logic                   r_atten;
    logic [PMW-1:0]         r_pmag;
    logic                   r_last;
    logic [SW:0]            r_scaled;
    logic signed [AW-1:0]   r_acc;
    logic                   r_out_valid;
    logic [SW-1:0]          r_out_data;

    logic [MW-1:0]          mul_a, mul_b;
    logic [PW-1:0]          mul_p;

    logic [SW-1:0]          in_sample;
    logic signed [PNW-1:0]  in_pan;
    logic [SW:0]            in_ext;
    logic [PNW:0]           pan_ext, pan_abs;
    logic [VOL_XW-1:0]      vol_pre;
    logic [VW-1:0]          vol_sel;
    logic [SW:0]            scl_now;
    logic [SW:0]            contrib_mag;
    logic signed [SW+1:0]   contrib;
    logic signed [AW:0]     sum;
    logic signed [AW-1:0]   acc_sat;
    logic [SW-1:0]          out_sat;
    logic                   acc_go;

    avpm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign in_sample = i_s_tdata[SW-1:0];
    assign in_pan    = i_s_tdata[SW+PNW-1:SW];
    assign in_ext    = {in_sample[SW-1], in_sample};
    assign pan_ext   = {in_pan[PNW-1], in_pan};
    assign pan_abs   = in_pan[PNW-1] ? (~pan_ext + 1'b1) : pan_ext;

    always_comb begin
        vol_pre = r_kind ? VOL_XW'(i_cfg.effect) : VOL_XW'(mul_p >> VOL_S);
        if (vol_pre > VOL_XW'(FULL_VOLUME)) begin
            vol_sel = VW'(FULL_VOLUME);
        end else begin
            vol_sel = vol_pre[VW-1:0];
        end
    end

    assign scl_now = (SW + 1)'(mul_p >> SCL_S);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_VMUL: begin
                mul_a = MW'(i_cfg.music);
                mul_b = MW'(i_cfg.master);
            end
            ST_VDIV: begin
                mul_a = MW'(mul_p[VOL_XW-1:0]);
                mul_b = MW'(VOL_R);
            end
            ST_SMUL: begin
                mul_a = MW'(r_mag);
                mul_b = MW'(vol_sel);
            end
            ST_SDIV: begin
                mul_a = MW'(mul_p[SCL_XW-1:0]);
                mul_b = MW'(SCL_R);
            end
            ST_PMUL: begin
                mul_a = MW'(scl_now);
                mul_b = MW'(PMW'(PF) - r_pmag);
            end
            ST_PDIV: begin
                mul_a = MW'(mul_p[PAN_XW-1:0]);
                mul_b = MW'(PAN_R);
            end
            default: ;
        endcase
    end

    always_comb begin
        contrib_mag = r_atten ? (SW + 1)'(mul_p >> PAN_S) : r_scaled;
        contrib = r_neg ? -$signed({1'b0, contrib_mag}) : $signed({1'b0, contrib_mag});
        sum = $signed({r_acc[AW-1], r_acc}) + (AW + 1)'(contrib);
        if (sum[AW] != sum[AW-1]) begin
            acc_sat = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            acc_sat = sum[AW-1:0];
        end
        if (acc_sat > OUT_MAX) begin
            out_sat = OUT_MAX[SW-1:0];
        end else if (acc_sat < OUT_MIN) begin
            out_sat = OUT_MIN[SW-1:0];
        end else begin
            out_sat = acc_sat[SW-1:0];
        end
    end

    // a last transfer waits here while the previous result is still held
    assign acc_go = (r_state == ST_ACC) && (!r_last || !r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_s_tvalid) n_state = ST_VMUL;
            ST_VMUL: n_state = ST_VDIV;
            ST_VDIV: n_state = ST_SMUL;
            ST_SMUL: n_state = ST_SDIV;
            ST_SDIV: n_state = ST_PMUL;
            ST_PMUL: n_state = ST_PDIV;
            ST_PDIV: n_state = ST_ACC;
            ST_ACC:  if (acc_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc_go) begin
                r_acc <= r_last ? '0 : acc_sat;
            end
            if (acc_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_mag   <= in_sample[SW-1] ? (~in_ext + 1'b1) : in_ext;
            r_neg   <= in_sample[SW-1];
            r_kind  <= i_s_tuser[0];
            r_atten <= (in_pan[PNW-1] && i_s_tuser[1]) ||
                       (!in_pan[PNW-1] && (in_pan != '0) && !i_s_tuser[1]);
            r_pmag  <= (pan_abs > (PNW + 1)'(PF)) ? PMW'(PF) : pan_abs[PMW-1:0];
            r_last  <= i_s_tlast;
        end
        if (r_state == ST_PMUL) begin
            r_scaled <= scl_now;
        end
        // keep the contribution while the multiplier output moves on
        if (r_state == ST_ACC) begin
            r_scaled <= contrib_mag;
            r_atten  <= 1'b0;
        end
        if (acc_go && r_last) begin
            r_out_data <= out_sat;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ hw/rtl/audio_volume_pan_mixer_top.sv @@
// Stereo PCM mixer slot: volume, pan, saturating accumulation.
// Depends on avpm_pkg, avpm_cfg, avpm_core (which uses avpm_mul).
//
// Usage:
//   Slave stream carries one contribution per transfer; tlast marks the
//   last contribution of an output slot. Master stream returns one
//   saturated 16-bit mixed sample per slot, after its tlast transfer.
//   Volumes are to be written on the cfg port (0 master, 1 music, 2 effect)
//   only while the block is idle, not enforced by it; other indexes are ignored.
// Sequence:
//   A contribution is accepted only after the previous one is done, then runs
//   six steps on the single shared multiplier (volume product, volume divide,
//   sample scale, scale divide, pan scale, pan divide) and an accumulate step.
//   Divides are reciprocal multiplies on that same multiplier. The mixed
//   sample appears on the master side in the cycle after the accumulate step.
// Reset:
//   Volumes return to 100, accumulator clears, no result is pending.
// Stall:
//   The result is held in an output register; the next contribution is
//   accepted meanwhile, and only a further tlast transfer waits in its
//   accumulate step until the held result has been taken.
module audio_volume_pan_mixer_top #(
    parameter int FULL_VOLUME = avpm_pkg::FULL_VOLUME_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [avpm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [avpm_pkg::VOL_W-1:0]         i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [avpm_pkg::IN_DATA_W-1:0]     i_s_tdata,   // source_sample, pan_amount
    input  logic [avpm_pkg::IN_USER_W-1:0]     i_s_tuser,   // source_kind, right_side
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [avpm_pkg::OUT_DATA_W-1:0]    o_m_tdata    // mixed_sample
);

    avpm_pkg::t_vol_cfg cfg;

    avpm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    avpm_core #(
        .FULL_VOLUME (FULL_VOLUME)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
